FILE: hdl/htsa_pkg.sv
// Package for the hexagonal tile source address unit.
// Holds fixed-point constants, register indexes and the cell index saturation helper.
// Depends on nothing; used by the top level and its checker.
package htsa_pkg;

  // Fraction bits of the rotation cosine and sine.
  localparam int TRIG_FRAC_BITS = 14;

  // Field widths fixed by the register map and the result format.
  localparam int REG_W      = 16;
  localparam int INV_W      = 14;
  localparam int FRAME_W    = 13;
  localparam int CELL_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int INVR_W     = 30;
  localparam int CS3_W      = 18;
  localparam int SAT_IN_W   = 24;

  // Number of register stages from input to output.
  localparam int PIPE_STAGES = 13;

  // Fixed-point constants: sqrt(3) and 1/sqrt(3) in Q.16, and 1/3 in Q.17.
  localparam logic [16:0] SQRT3_Q16     = 17'd113512;
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
  localparam logic [15:0] DIV3_RECIP    = 16'd43691;

  // Cell index limits.
  localparam logic [SAT_IN_W-1:0] CELL_POS_LIM = 24'd1023;
  localparam logic [SAT_IN_W-1:0] CELL_NEG_LIM = 24'd1024;
  localparam logic signed [CELL_W-1:0] CELL_MAX = 11'sd1023;
  localparam logic signed [CELL_W-1:0] CELL_MIN = -11'sd1024;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_ROT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ROT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

  // Register reset values.
  localparam logic [REG_W-1:0]   RST_CENTER  = 16'd32768;
  localparam logic [REG_W-1:0]   RST_COS     = 16'd16384;
  localparam logic [REG_W-1:0]   RST_SIN     = 16'd0;
  localparam logic [REG_W-1:0]   RST_CELL    = 16'd12800;
  localparam logic [INV_W-1:0]   RST_INV     = 14'd1311;
  localparam logic [FRAME_W-1:0] RST_FRAME   = 13'd4096;

  // Saturate a rounded magnitude with its sign to the cell index range.
  function automatic logic signed [CELL_W-1:0] sat_cell(input logic neg,
                                                        input logic [SAT_IN_W-1:0] q);
    logic [SAT_IN_W-1:0] nq;
    nq = -q;
    if (neg) begin
      sat_cell = (q > CELL_NEG_LIM) ? CELL_MIN : nq[CELL_W-1:0];
    end else begin
      sat_cell = (q > CELL_POS_LIM) ? CELL_MAX : q[CELL_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/hex_tile_source_address_unit.sv
// Hexagonal tile source address unit: maps a destination pixel to the clamped center
// of its rotated hexagonal cell. Depends on htsa_pkg.
//
//  Channel  | Direction | Handshake          | Contents (lowest bit first)
//  ---------+-----------+--------------------+-----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | pixel_x, pixel_y
//  m_       | out       | m_tvalid/m_tready  | source_x, source_y, cell_column, cell_row
//  cfg_     | in        | cfg_we             | register cfg_index gets cfg_data
//
// One request per clock while the output is not stalled; a request accepted into stage 1
// moves through the 13-stage pipeline to the output register; the widest step is the
// 35 x 30 row multiply.
// Reset clears the valid bits and loads the register reset values.
// A stalled output holds each full stage whose later stages are all full; other stages
// keep filling, so bubbles close up. s_tready is an OR chain back from m_tready.
// Values derived from the registers (row pitch, scaled reciprocal) are registered and
// follow a write in the cycle after the register they come from takes it.
module hex_tile_source_address_unit
  import htsa_pkg::*;
#(
  parameter int COORD_BITS = 12,
  localparam int IN_DW  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * COORD_BITS + 2 * CELL_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DW-1:0]     s_tdata,   // pixel_x, pixel_y
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_DW-1:0]    m_tdata,   // source_x, source_y, cell_column, cell_row
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  // Datapath widths.
  localparam int PXW   = COORD_BITS + 4;
  localparam int DXW   = ((PXW > REG_W) ? PXW : REG_W) + 1;
  localparam int PW    = DXW + REG_W;
  localparam int RW    = PW + 1;
  localparam int MCW   = RW + INV_W;
  localparam int CS    = 20 + TRIG_FRAC_BITS;
  localparam int TW    = MCW + 2 - CS;
  localparam int DW    = RW + 1;
  localparam int MRW   = DW + INVR_W;
  localparam int RS    = 36 + TRIG_FRAC_BITS;
  localparam int Q2W   = MRW + 1 - RS;
  localparam int PITW  = 13 + TRIG_FRAC_BITS;
  localparam int HALFW = PITW - 1;
  localparam int HXPW  = CELL_W + CS3_W + 1;
  localparam int HYPW  = CELL_W + PITW + 1;
  localparam int HW    = HYPW + 1;
  localparam int SPW   = HW + REG_W;
  localparam int SW    = SPW + 2;
  localparam int SRC_SHIFT = 4 + 2 * TRIG_FRAC_BITS;
  localparam int RSW   = SW - SRC_SHIFT;
  localparam int LIMW  = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;
  localparam int QMW   = 28;

  localparam logic [MCW:0]      COL_RND = (MCW + 1)'(3) << (CS - 2);
  localparam logic [MRW:0]      ROW_RND = (MRW + 1)'(1) << (RS - 1);
  localparam logic [TW-1:0]     TC_MAX  = TW'(4095);
  localparam logic [LIMW-1:0]   SRC_TOP = LIMW'((1 << COORD_BITS) - 1);

  // Configuration registers.
  logic        [REG_W-1:0]   center_x, center_y, cell_size;
  logic signed [REG_W-1:0]   cos_rot, sin_rot;
  logic        [INV_W-1:0]   inv_cell_size;
  logic        [FRAME_W-1:0] frame_width, frame_height;

  // Values derived from the registers.
  logic [32:0]       pitch_prod;
  logic [PITW-1:0]   pitch_r;
  logic [HALFW-1:0]  half_r;
  logic [INVR_W-1:0] invr_r;
  logic [CS3_W-1:0]  cs3_r;

  // Pipeline control.
  logic [PIPE_STAGES:1] v, en;

  // Clamp a source coordinate in Q.(4+2T) to the frame.
  function automatic logic [COORD_BITS-1:0] clamp_src(input logic signed [SW-1:0] val,
                                                      input logic [FRAME_W-1:0] frame);
    logic [LIMW-1:0] lim;
    logic [RSW-1:0]  r;
    lim = (frame == '0) ? '0 : LIMW'(frame - 1'b1);
    if (lim > SRC_TOP) begin
      lim = SRC_TOP;
    end
    r = val[SW-1:SRC_SHIFT];
    if (val[SW-1]) begin
      clamp_src = '0;
    end else if (r > RSW'(lim)) begin
      clamp_src = lim[COORD_BITS-1:0];
    end else begin
      clamp_src = r[COORD_BITS-1:0];
    end
  endfunction

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= RST_CENTER;
      center_y      <= RST_CENTER;
      cos_rot       <= RST_COS;
      sin_rot       <= RST_SIN;
      cell_size     <= RST_CELL;
      inv_cell_size <= RST_INV;
      frame_width   <= RST_FRAME;
      frame_height  <= RST_FRAME;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:     center_x      <= cfg_data;
        REG_CENTER_Y:     center_y      <= cfg_data;
        REG_COS_ROT:      cos_rot       <= cfg_data;
        REG_SIN_ROT:      sin_rot       <= cfg_data;
        REG_CELL_SIZE:    cell_size     <= cfg_data;
        REG_INV_CELL:     inv_cell_size <= cfg_data[INV_W-1:0];
        REG_FRAME_WIDTH:  frame_width   <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height  <= cfg_data[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Row pitch, half pitch, 1/(size*sqrt3) scale and 3*size, refreshed every cycle.
  assign pitch_prod = 33'(cell_size) * 33'(SQRT3_Q16);
  assign half_r     = pitch_r[PITW-1:1];

  always_ff @(posedge clk) begin
    pitch_r <= pitch_prod[32:20-TRIG_FRAC_BITS];
    invr_r  <= INVR_W'(inv_cell_size) * INVR_W'(INV_SQRT3_Q16);
    cs3_r   <= CS3_W'(cell_size) * CS3_W'(3);
  end

  // Stage enables: a stage loads when it is empty or the stage after it moves.
  always_comb begin
    en[PIPE_STAGES] = !v[PIPE_STAGES] || m_tready;
    for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = v[PIPE_STAGES];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= PIPE_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: offsets from the center in Q.4.
  logic [COORD_BITS-1:0]  pixel_x, pixel_y;
  logic signed [DXW-1:0]  dx_next, dy_next, dx1, dy1;

  assign pixel_x = s_tdata[COORD_BITS-1:0];
  assign pixel_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign dx_next = DXW'({pixel_x, 4'b0000}) - DXW'(center_x);
  assign dy_next = DXW'({pixel_y, 4'b0000}) - DXW'(center_y);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx1 <= dx_next;
      dy1 <= dy_next;
    end
  end

  // Stage 2: the four rotation products.
  logic signed [PW-1:0] pxc_next, pys_next, pyc_next, pxs_next;
  logic signed [PW-1:0] pxc2, pys2, pyc2, pxs2;

  assign pxc_next = PW'(dx1) * PW'(cos_rot);
  assign pys_next = PW'(dy1) * PW'(sin_rot);
  assign pyc_next = PW'(dy1) * PW'(cos_rot);
  assign pxs_next = PW'(dx1) * PW'(sin_rot);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pxc2 <= pxc_next;
      pys2 <= pys_next;
      pyc2 <= pyc_next;
      pxs2 <= pxs_next;
    end
  end

  // Stage 3: rotated offsets; x is split into sign and magnitude.
  logic signed [RW-1:0] rx_next, ry_next, ry3;
  logic [RW-1:0]        arx_next, arx3;
  logic                 rneg3;

  assign rx_next  = RW'(pxc2) + RW'(pys2);
  assign ry_next  = RW'(pyc2) - RW'(pxs2);
  assign arx_next = rx_next[RW-1] ? RW'(-rx_next) : RW'(rx_next);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      arx3  <= arx_next;
      rneg3 <= rx_next[RW-1];
      ry3   <= ry_next;
    end
  end

  // Stage 4: column magnitude times the reciprocal cell size.
  logic [MCW-1:0]       mcol_next, mcol4;
  logic                 rneg4;
  logic signed [RW-1:0] ry4;

  assign mcol_next = MCW'(arx3) * MCW'(inv_cell_size);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mcol4 <= mcol_next;
      rneg4 <= rneg3;
      ry4   <= ry3;
    end
  end

  // Stage 5: add the rounding half and drop fraction bits; large values saturate to all ones here.
  logic [MCW:0]         csum;
  logic [TW-1:0]        tc_full;
  logic [11:0]          tc_next, tc5;
  logic                 rneg5;
  logic signed [RW-1:0] ry5;

  assign csum    = (MCW + 1)'(mcol4) + COL_RND;
  assign tc_full = csum[MCW:CS-1];
  assign tc_next = (tc_full > TC_MAX) ? 12'hFFF : tc_full[11:0];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tc5   <= tc_next;
      rneg5 <= rneg4;
      ry5   <= ry4;
    end
  end

  // Stage 6: exact division by three, then the saturated column index.
  logic [QMW-1:0]            qm;
  logic [CELL_W-1:0]         qc;
  logic signed [CELL_W-1:0]  col_next, col6;
  logic signed [RW-1:0]      ry6;

  assign qm       = QMW'(tc5) * QMW'(DIV3_RECIP);
  assign qc       = qm[QMW-1:17];
  assign col_next = sat_cell(rneg5, SAT_IN_W'(qc));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      col6 <= col_next;
      ry6  <= ry5;
    end
  end

  // Stage 7: odd columns move down half a row; row offset as sign and magnitude.
  logic [HALFW-1:0]         off_sel, off7;
  logic signed [DW-1:0]     ry_ext, offd_ext, d_next;
  logic [DW-1:0]            ad_next, ad7;
  logic                     dneg7;
  logic signed [CELL_W-1:0] col7;

  assign off_sel  = col6[0] ? half_r : '0;
  assign ry_ext   = DW'(ry6);
  assign offd_ext = DW'(off_sel);
  assign d_next   = ry_ext - offd_ext;
  assign ad_next  = d_next[DW-1] ? DW'(-d_next) : DW'(d_next);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      ad7   <= ad_next;
      dneg7 <= d_next[DW-1];
      off7  <= off_sel;
      col7  <= col6;
    end
  end

  // Stage 8: row magnitude times 1/(size*sqrt3).
  logic [MRW-1:0]           mrow_next, mrow8;
  logic                     dneg8;
  logic [HALFW-1:0]         off8;
  logic signed [CELL_W-1:0] col8;

  assign mrow_next = MRW'(ad7) * MRW'(invr_r);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      mrow8 <= mrow_next;
      dneg8 <= dneg7;
      off8  <= off7;
      col8  <= col7;
    end
  end

  // Stage 9: round half away from zero and saturate the row index.
  logic [MRW:0]             rsum;
  logic [Q2W-1:0]           q2;
  logic signed [CELL_W-1:0] row_next, row9, col9;
  logic [HALFW-1:0]         off9;

  assign rsum     = (MRW + 1)'(mrow8) + ROW_RND;
  assign q2       = rsum[MRW:RS];
  assign row_next = sat_cell(dneg8, SAT_IN_W'(q2));

  always_ff @(posedge clk) begin
    if (en[9]) begin
      row9 <= row_next;
      col9 <= col8;
      off9 <= off8;
    end
  end

  // Stage 10: cell center products in the grid frame.
  logic signed [CS3_W:0]    cs3_s;
  logic signed [PITW:0]     pitch_s;
  logic signed [HXPW-1:0]   hxp_next, hxp10;
  logic signed [HYPW-1:0]   hyp_next, hyp10;
  logic [HALFW-1:0]         off10;
  logic signed [CELL_W-1:0] col10, row10;

  assign cs3_s    = {1'b0, cs3_r};
  assign pitch_s  = {1'b0, pitch_r};
  assign hxp_next = HXPW'(col9) * HXPW'(cs3_s);
  assign hyp_next = HYPW'(row9) * HYPW'(pitch_s);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      hxp10 <= hxp_next;
      hyp10 <= hyp_next;
      off10 <= off9;
      col10 <= col9;
      row10 <= row9;
    end
  end

  // Stage 11: scale and offset the center, then the back-rotation products.
  logic signed [HW-1:0]     hx_ext, hx_val, hy_ext, offh_ext, hy_val;
  logic signed [SPW-1:0]    pa_next, pb_next, pc_next, pd_next;
  logic signed [SPW-1:0]    pa11, pb11, pc11, pd11;
  logic signed [CELL_W-1:0] col11, row11;

  assign hx_ext   = HW'(hxp10);
  assign hx_val   = hx_ext <<< (TRIG_FRAC_BITS - 5);
  assign hy_ext   = HW'(hyp10);
  assign offh_ext = HW'(off10);
  assign hy_val   = hy_ext + offh_ext;
  assign pa_next  = SPW'(hx_val) * SPW'(cos_rot);
  assign pb_next  = SPW'(hy_val) * SPW'(sin_rot);
  assign pc_next  = SPW'(hx_val) * SPW'(sin_rot);
  assign pd_next  = SPW'(hy_val) * SPW'(cos_rot);

  always_ff @(posedge clk) begin
    if (en[11]) begin
      pa11  <= pa_next;
      pb11  <= pb_next;
      pc11  <= pc_next;
      pd11  <= pd_next;
      col11 <= col10;
      row11 <= row10;
    end
  end

  // Stage 12: add the grid center back.
  logic signed [SW-1:0]     cx_ext, cy_ext, sx_next, sy_next, sx12, sy12;
  logic signed [CELL_W-1:0] col12, row12;

  assign cx_ext  = SW'(center_x);
  assign cy_ext  = SW'(center_y);
  assign sx_next = (cx_ext <<< (2 * TRIG_FRAC_BITS)) + SW'(pa11) - SW'(pb11);
  assign sy_next = (cy_ext <<< (2 * TRIG_FRAC_BITS)) + SW'(pc11) + SW'(pd11);

  always_ff @(posedge clk) begin
    if (en[12]) begin
      sx12  <= sx_next;
      sy12  <= sy_next;
      col12 <= col11;
      row12 <= row11;
    end
  end

  // Stage 13: truncate, clamp to the frame and hold in the output register.
  logic [COORD_BITS-1:0]    source_x, source_y;
  logic signed [CELL_W-1:0] cell_column, cell_row;

  always_ff @(posedge clk) begin
    if (en[13]) begin
      source_x    <= clamp_src(sx12, frame_width);
      source_y    <= clamp_src(sy12, frame_height);
      cell_column <= col12;
      cell_row    <= row12;
    end
  end

  assign m_tdata = OUT_DW'({cell_row, cell_column, source_y, source_x});

endmodule

FILE: hdl/htsa_checker.sv
// Port-level checker for the hexagonal tile source address unit, bound to the top level.
// Depends on htsa_pkg; watches the stream and configuration ports only.
module htsa_checker
  import htsa_pkg::*;
#(
  parameter int COORD_BITS = 12,
  localparam int OUT_DW = ((2 * COORD_BITS + 2 * CELL_W + 7) / 8) * 8
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_DW-1:0]    m_tdata,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [REG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(PIPE_STAGES + 1);

  logic [COORD_BITS-1:0] src_x, src_y;
  logic [FRAME_W-1:0]    fw, fh;
  logic [CNT_W-1:0]      cnt, cnt_next;

  assign src_x = m_tdata[COORD_BITS-1:0];
  assign src_y = m_tdata[2*COORD_BITS-1:COORD_BITS];

  // Shadow copies of the frame size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= RST_FRAME;
      fh <= RST_FRAME;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: fh <= cfg_data[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Requests accepted but not yet delivered.
  assign cnt_next = cnt + CNT_W'(s_tvalid && s_tready) - CNT_W'(m_tvalid && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // Every result belongs to an accepted request.
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt != '0)
    else $error("result without an outstanding request");

  // No more requests in flight than the pipeline holds.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(PIPE_STAGES))
    else $error("more requests in flight than pipeline stages");

  // Source addresses stay inside the frame.
  a_clamp_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((fw == '0) && (src_x == '0)) || ((fw != '0) && (src_x < fw)))
    else $error("source_x outside frame");

  a_clamp_y: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((fh == '0) && (src_y == '0)) || ((fh != '0) && (src_y < fh)))
    else $error("source_y outside frame");

endmodule

bind hex_tile_source_address_unit htsa_checker #(.COORD_BITS(COORD_BITS)) u_htsa_checker (.*);
